[rtl/sxpk_pkg.sv]
// shared constants and types for the sysex event packetizer
package sxpk_pkg;

  localparam int unsigned DataW  = 8;
  localparam int unsigned CableW = 4;
  localparam int unsigned CountW = 16;
  localparam int unsigned PktW   = 32;
  localparam int unsigned AddrW  = 3;

  // code index nibbles of the event header
  localparam logic [3:0] CODE_CONTINUE  = 4'h4;
  localparam logic [3:0] CODE_END_ONE   = 4'h5;
  localparam logic [3:0] CODE_END_TWO   = 4'h6;
  localparam logic [3:0] CODE_END_THREE = 4'h7;

  localparam logic [CountW-1:0] MAX_BYTES_RESET = 16'd1024;
  localparam logic [CountW-1:0] COUNT_SAT       = 16'hFFFF;

  // register index of max_message_bytes
  localparam logic REG_MAX_BYTES = 1'b0;

  typedef enum logic [1:0] {
    OUTCOME_OK        = 2'd0,
    OUTCOME_TOO_SHORT = 2'd1,
    OUTCOME_TOO_LONG  = 2'd2
  } outcome_t;

endpackage

[rtl/sysex_event_packetizer_unit.sv]
// sysex event packetizer: groups message bytes into four-byte event packets
// The block takes one message byte per cycle on the s_axis side, with tlast
// on the final byte of a message and the cable number in tuser, and gives at
// most one event packet per byte on the m_axis side. The grouping state
// (two pending bytes, a pending count, a saturating byte counter, the
// latched cable and a drop flag) is updated by short logic between the
// input handshake and a single output register, so a byte is accepted in
// every cycle while the output register is empty or being taken. A packet
// is registered and appears in the cycle after the byte that completes it.
// Full groups of three that are not final go out with code 4; the final
// group of one, two or three bytes gets code 5, 6 or 7 with zeros in unused
// bytes. tuser on the output gives the outcome: 0 packet, 1 message of a
// single byte, 2 message longer than max_message_bytes (register at byte
// address 0, reset 1024), in which case the excess bytes and pending bytes
// are dropped and only the final byte gives a result with an empty packet.
// Packets sent before a message turns out too long are not recalled.
module sysex_event_packetizer_unit (
  input  logic                       clk,
  input  logic                       rst,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sxpk_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // byte stream in
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,  // [7:0] data_byte
  input  logic                       s_axis_tlast,  // final_byte
  input  logic [3:0]                 s_axis_tuser,  // [3:0] cable_number
  // event packets out
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [7:0] packet_header, [15:8] payload_first, [23:16] payload_second,
  // [31:24] payload_third
  output logic [31:0]                m_axis_tdata,
  output logic                       m_axis_tlast,  // message_end
  output logic [1:0]                 m_axis_tuser   // [1:0] outcome
);
  import sxpk_pkg::*;

  logic [CountW-1:0] max_message_bytes;

  logic [DataW-1:0]  pending_bytes [2];
  logic [DataW-1:0]  pending_bytes_next [2];
  logic [1:0]        pending_count, pending_count_next;
  logic [CountW-1:0] bytes_seen, bytes_seen_next;
  logic [CableW-1:0] message_cable, message_cable_next;
  logic              dropping_rest, dropping_rest_next;

  logic              in_xfer;
  logic              cfg_write;
  logic              first, over;
  logic [CableW-1:0] cable_eff;
  logic              res_valid;
  logic [PktW-1:0]   res_data;
  outcome_t          res_outcome;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_MAX_BYTES) ? {16'd0, max_message_bytes} : 32'd0;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  assign first     = (bytes_seen == '0);
  assign over      = (bytes_seen >= max_message_bytes);
  assign cable_eff = first ? s_axis_tuser : message_cable;

  always_comb begin
    pending_bytes_next = pending_bytes;
    pending_count_next = pending_count;
    bytes_seen_next    = bytes_seen;
    message_cable_next = message_cable;
    dropping_rest_next = dropping_rest;
    res_valid          = 1'b0;
    res_data           = '0;
    res_outcome        = OUTCOME_OK;
    if (in_xfer) begin
      message_cable_next = cable_eff;
      if (bytes_seen != COUNT_SAT) begin
        bytes_seen_next = bytes_seen + 16'd1;
      end
      if (s_axis_tlast && first) begin
        res_valid   = 1'b1;
        res_outcome = OUTCOME_TOO_SHORT;
      end else if (dropping_rest || over) begin
        dropping_rest_next    = 1'b1;
        pending_bytes_next[0] = '0;
        pending_bytes_next[1] = '0;
        pending_count_next    = 2'd0;
        if (s_axis_tlast) begin
          res_valid   = 1'b1;
          res_outcome = OUTCOME_TOO_LONG;
        end
      end else if (s_axis_tlast) begin
        res_valid = 1'b1;
        case (pending_count)
          2'd0:    res_data = {8'd0, 8'd0, s_axis_tdata, cable_eff, CODE_END_ONE};
          2'd1:    res_data = {8'd0, s_axis_tdata, pending_bytes[0],
                               cable_eff, CODE_END_TWO};
          default: res_data = {s_axis_tdata, pending_bytes[1], pending_bytes[0],
                               cable_eff, CODE_END_THREE};
        endcase
      end else if (pending_count == 2'd2) begin
        res_valid = 1'b1;
        res_data  = {s_axis_tdata, pending_bytes[1], pending_bytes[0],
                     cable_eff, CODE_CONTINUE};
        pending_bytes_next[0] = '0;
        pending_bytes_next[1] = '0;
        pending_count_next    = 2'd0;
      end else begin
        pending_bytes_next[pending_count[0]] = s_axis_tdata;
        pending_count_next = pending_count + 2'd1;
      end
      // any final byte closes the message
      if (s_axis_tlast) begin
        pending_bytes_next[0] = '0;
        pending_bytes_next[1] = '0;
        pending_count_next    = 2'd0;
        bytes_seen_next       = '0;
        message_cable_next    = '0;
        dropping_rest_next    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_message_bytes <= MAX_BYTES_RESET;
      pending_bytes[0]  <= '0;
      pending_bytes[1]  <= '0;
      pending_count     <= 2'd0;
      bytes_seen        <= '0;
      message_cable     <= '0;
      dropping_rest     <= 1'b0;
      m_axis_tvalid     <= 1'b0;
    end else begin
      if (cfg_write && paddr[2] == REG_MAX_BYTES) begin
        max_message_bytes <= pwdata[CountW-1:0];
      end
      pending_bytes <= pending_bytes_next;
      pending_count <= pending_count_next;
      bytes_seen    <= bytes_seen_next;
      message_cable <= message_cable_next;
      dropping_rest <= dropping_rest_next;
      if (s_axis_tready) begin
        m_axis_tvalid <= res_valid;
      end
    end
  end

  // result payload, loaded when the output register is free and a result is ready
  always_ff @(posedge clk) begin
    if (s_axis_tready && res_valid) begin
      m_axis_tdata <= res_data;
      m_axis_tlast <= s_axis_tlast;
      m_axis_tuser <= res_outcome;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    pending_count != 2'd3)
    else $error("pending count out of range");

  a_drop_empty: assert property (@(posedge clk) disable iff (rst)
    dropping_rest |-> (pending_count == 2'd0))
    else $error("pending bytes kept while dropping");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && s_axis_tlast) |=> (bytes_seen == '0 && !dropping_rest))
    else $error("message state not cleared after final byte");

  a_bad_empty: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != OUTCOME_OK) |-> (m_axis_tlast && m_axis_tdata == '0))
    else $error("error result carries packet data");

  a_continue_code: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[3:0] == CODE_CONTINUE))
    else $error("non-final packet without continue code");
`endif

endmodule
